/* rtl/fractional_delay_line_linear_assert.svh */
// assertion macros for the fractional delay line checker
// expects i_clk and i_rst_n in the scope of use
`ifndef FRACTIONAL_DELAY_LINE_LINEAR_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_LINEAR_ASSERT_SVH

// same-cycle implication, off during reset
`define FDL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdl checker: same-cycle rule violated");

// next-cycle implication, off during reset
`define FDL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdl checker: next-cycle rule violated");

`endif

/* rtl/fdl_pkg.sv */
// shared types and constants for the fractional delay line
// used by the controller, the datapath and the top level
package fdl_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DELAY_W       = 28;
    localparam int LEN_W         = 11;
    localparam int SLOPE_W       = DELAY_W + 1;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = DELAY_W;
    localparam int DEF_BUF_DEPTH = 4096;
    localparam int FRAC_W        = 16;
    localparam int IDEL_W        = DELAY_W - FRAC_W;

    // divider runs one quotient bit per cycle over the delay magnitude
    localparam int DIV_STEPS = DELAY_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DELAY_W-1:0] DELAY_ONE   = DELAY_W'(1) << FRAC_W;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = {DELAY_W{1'b1}};
    localparam logic [LEN_W-1:0]   RAMP_LEN_RST = LEN_W'(64);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SLOPE,
        S_RAMP,
        S_RD1,
        S_RD2,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;     // capture the input item
        logic div_start;  // load the slope divider
        logic div_step;   // one quotient bit
        logic load_slope; // take quotient, arm the ramp
        logic ramp_step;  // advance the current delay
        logic rd_tap2;    // read address selects the older tap
        logic cap_d1;     // latch the first tap
        logic cap_prod;   // latch the interpolation product
        logic commit;     // write result, store sample, move pointer
    } t_cmd;

    typedef struct packed {
        logic pending;    // a new target waits for its ramp
        logic div_last;   // divider is on its final bit
        logic out_free;   // output register can take a result
    } t_status;

endpackage

/* rtl/fdl_ctrl.sv */
// sequencer for the fractional delay line
// depends on fdl_pkg for the state type and the command and status structs
module fdl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fdl_pkg::t_status i_status,
    output logic             o_in_ready,
    output fdl_pkg::t_cmd    o_cmd
);
    import fdl_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.pending ? S_DIV : S_RAMP;
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_SLOPE;
                end
            end
            S_SLOPE: n_state = S_RAMP;
            S_RAMP:  n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.accept    = i_in_valid;
                o_cmd.div_start = i_in_valid && i_status.pending;
            end
            S_DIV:   o_cmd.div_step   = 1'b1;
            S_SLOPE: o_cmd.load_slope = 1'b1;
            S_RAMP:  o_cmd.ramp_step  = 1'b1;
            S_RD1:   o_cmd.rd_tap2    = 1'b0;
            S_RD2: begin
                o_cmd.rd_tap2 = 1'b1;
                o_cmd.cap_d1  = 1'b1;
            end
            S_MUL:   o_cmd.cap_prod   = 1'b1;
            S_OUT:   o_cmd.commit     = i_status.out_free;
            default: o_cmd            = '0;
        endcase
    end

endmodule

/* rtl/fdl_datapath.sv */
// datapath of the fractional delay line: config registers, ramp, slope divider,
// sample ring buffer, interpolator and output register; depends on fdl_pkg
module fdl_datapath #(
    parameter int BUF_DEPTH = fdl_pkg::DEF_BUF_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_out_ready,
    input  fdl_pkg::t_cmd                       i_cmd,
    output fdl_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] o_sample_out
);
    import fdl_pkg::*;

    localparam int AW   = $clog2(BUF_DEPTH);
    localparam int CNTW = AW + 1;
    localparam int CMPW = (CNTW > IDEL_W + 1) ? CNTW : IDEL_W + 1;
    localparam logic [32:0] DLY_HI = 33'(BUF_DEPTH - 1) << FRAC_W;
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(BUF_DEPTH);

    // configuration and ramp state
    logic [DELAY_W-1:0]        r_target;
    logic [LEN_W-1:0]          r_len;
    logic                      r_pending;
    logic [DELAY_W-1:0]        r_current;
    logic signed [SLOPE_W-1:0] r_slope;
    logic [LEN_W-1:0]          r_left;

    // divider
    logic [LEN_W-1:0]     r_rem;
    logic [DELAY_W-1:0]   r_quo;
    logic [LEN_W-1:0]     r_dsor;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // buffer and interpolation
    logic signed [SAMPLE_W-1:0] r_mem [BUF_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_d1;
    logic signed [2*SAMPLE_W+1:0] r_prod;
    logic [AW-1:0]              r_wp;
    logic [CNTW-1:0]            r_count;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic [DELAY_W-1:0]          w_tgt;
    logic signed [SLOPE_W-1:0]   w_diff;
    logic [LEN_W:0]              w_rem_sh;
    logic                        w_ge;
    logic signed [SLOPE_W:0]     w_nd;
    logic [DELAY_W-1:0]          w_nd_sat;
    logic [IDEL_W-1:0]           w_idel;
    logic [IDEL_W:0]             w_age2;
    logic                        w_valid1;
    logic                        w_valid2;
    logic [AW-1:0]               w_raddr;
    logic signed [SAMPLE_W-1:0]  w_d2;
    logic signed [SAMPLE_W:0]    w_tap_diff;
    logic signed [SAMPLE_W:0]    w_frac;
    logic signed [2*SAMPLE_W+1:0] w_round;
    logic signed [2*SAMPLE_W+1:0] w_corr;

    // clamp the target to one sample .. depth minus one
    always_comb begin
        if (r_target < DELAY_ONE) begin
            w_tgt = DELAY_ONE;
        end else if ({5'b0, r_target} > DLY_HI) begin
            w_tgt = DLY_HI[DELAY_W-1:0];
        end else begin
            w_tgt = r_target;
        end
    end

    // signed distance to the target and one restoring division step
    assign w_diff   = SLOPE_W'({1'b0, w_tgt}) - SLOPE_W'({1'b0, r_current});
    assign w_rem_sh = {r_rem, r_quo[DELAY_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dsor};

    // next delay on the ramp, held inside the 28-bit range
    assign w_nd = signed'({2'b00, r_current}) + {r_slope[SLOPE_W-1], r_slope};
    always_comb begin
        if (w_nd < 0) begin
            w_nd_sat = '0;
        end else if (w_nd > signed'({2'b00, DELAY_MAX})) begin
            w_nd_sat = DELAY_MAX;
        end else begin
            w_nd_sat = w_nd[DELAY_W-1:0];
        end
    end

    // tap ages, validity against the fill count, read address
    assign w_idel   = r_current[DELAY_W-1:FRAC_W];
    assign w_age2   = {1'b0, w_idel} + (IDEL_W+1)'(1);
    assign w_valid1 = (w_idel != '0) && (CMPW'(w_idel) <= CMPW'(r_count));
    assign w_valid2 = CMPW'(w_age2) <= CMPW'(r_count);
    assign w_raddr  = i_cmd.rd_tap2 ? AW'(r_wp - AW'(w_idel) - AW'(1))
                                    : AW'(r_wp - AW'(w_idel));

    // interpolation terms
    assign w_d2       = w_valid2 ? r_rdata : '0;
    assign w_tap_diff = {w_d2[SAMPLE_W-1], w_d2} - {r_d1[SAMPLE_W-1], r_d1};
    assign w_frac     = {1'b0, r_current[FRAC_W-1:0]};
    assign w_round    = r_prod + (2*SAMPLE_W+2)'(32768);
    assign w_corr     = w_round >>> FRAC_W;

    // configuration and ramp control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= DELAY_ONE;
            r_len     <= RAMP_LEN_RST;
            r_pending <= 1'b0;
            r_current <= DELAY_ONE;
            r_slope   <= '0;
            r_left    <= '0;
        end else begin
            if (i_cmd.load_slope) begin
                r_slope   <= r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});
                r_left    <= r_dsor;
                r_pending <= 1'b0;
            end
            if (i_cmd.ramp_step && (r_left != '0)) begin
                r_left    <= r_left - LEN_W'(1);
                r_current <= (r_left == LEN_W'(1)) ? w_tgt : w_nd_sat;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TARGET_DELAY: begin
                        r_target  <= i_cfg_data;
                        r_pending <= 1'b1;
                    end
                    REG_RAMP_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // serial slope divider on magnitudes, sign fixed afterwards
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg     <= w_diff[SLOPE_W-1];
            r_quo     <= w_diff[SLOPE_W-1] ? DELAY_W'(-w_diff) : w_diff[DELAY_W-1:0];
            r_rem     <= '0;
            r_dsor    <= (r_len == '0) ? LEN_W'(1) : r_len;
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? LEN_W'(w_rem_sh - {1'b0, r_dsor}) : w_rem_sh[LEN_W-1:0];
            r_quo     <= {r_quo[DELAY_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    // ring buffer: registered read, write at commit
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (i_cmd.commit) begin
            r_mem[r_wp] <= r_sample;
        end
    end

    // sample capture and interpolation pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.cap_d1) begin
            r_d1 <= w_valid1 ? r_rdata : '0;
        end
        if (i_cmd.cap_prod) begin
            r_prod <= w_frac * w_tap_diff;
        end
        if (i_cmd.commit) begin
            r_out_data <= r_d1 + w_corr[SAMPLE_W-1:0];
        end
    end

    // write pointer, fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_wp        <= r_wp + AW'(1);
                r_out_valid <= 1'b1;
                if (r_count != CNT_FULL) begin
                    r_count <= r_count + CNTW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pending  = r_pending;
    assign o_status.div_last = (r_div_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out_data;

endmodule

/* rtl/fractional_delay_line_linear.sv */
// sequence: an accepted item passes S_RAMP, S_RD1, S_RD2, S_MUL and S_OUT; when a new
// target starts its ramp, the bit-serial slope divider and the slope load come first
// one item at a time: a new item is taken only in S_IDLE, after the result is committed;
// the two ring buffer taps are read in turn through its single read port
// reset: synchronous active low; buffer content needs no clearing, unwritten
// taps are masked by the fill count
module fractional_delay_line_linear #(
    parameter int BUF_DEPTH = fdl_pkg::DEF_BUF_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] o_sample_out
);
    import fdl_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    fdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath
    fdl_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_out_ready  (i_out_ready),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

/* rtl/fdl_checker.sv */
// port-level checker for the fractional delay line, bound to the top level
// depends on fractional_delay_line_linear_assert.svh for the assertion macros
`include "fractional_delay_line_linear_assert.svh"

module fdl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_sample_out
);
    logic [1:0] r_inflight;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else begin
            r_inflight <= r_inflight + 2'((i_in_valid && o_in_ready) ? 1 : 0)
                                     - 2'((o_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    // one item at a time: ready drops right after an accept
    `FDL_ASSERT_NEXT(a_ready_drops, i_in_valid && o_in_ready, !o_in_ready)
    // no result without an accepted item behind it
    `FDL_ASSERT_IMPL(a_no_orphan_out, o_out_valid, r_inflight != 2'd0)
    // with a result waiting and one in flight, no new item is taken
    `FDL_ASSERT_IMPL(a_full_blocks, r_inflight == 2'd2, !o_in_ready)
    // a stalled result holds
    `FDL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_sample_out))

endmodule

bind fractional_delay_line_linear fdl_checker u_fdl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);
